### hdl/assert_macros.svh
// Assertion macros used by the checker file hpt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/hpt_pkg.sv
// Package for the Haar pair threshold denoiser: widths, defaults, queue status type.
// No dependencies.
`timescale 1ns / 1ps

package hpt_pkg;

	localparam int SAMPLE_WIDTH_DEF = 12;
	localparam int THRESH_W         = 13;
	localparam int COUNT_W          = 32;
	localparam int ABS_W            = 48;
	localparam int SQ_W             = 56;
	localparam int QUEUE_DEPTH      = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} hpt_qstat_t;

endpackage

### hdl/hpt_queue.sv
// Short pair queue between the front and the back part.
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_queue import hpt_pkg::*; #(
	parameter int ENTRY_W = 4 * SAMPLE_WIDTH_DEF + 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [ENTRY_W-1:0] push_data,
	input  logic               pop,
	output logic [ENTRY_W-1:0] head,
	output hpt_qstat_t         qstat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ENTRY_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/hpt_front.sv
// Front part: pairs incoming samples, forms Haar sum and difference, applies the threshold.
// Depends on hpt_pkg; feeds hpt_queue.
`timescale 1ns / 1ps

module hpt_front import hpt_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [THRESH_W-1:0]            threshold,
	input  hpt_qstat_t                     qstat,
	output logic                           push,
	output logic [4*SAMPLE_WIDTH+2:0]      push_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CMP_W = (SW + 1 > THRESH_W) ? SW + 1 : THRESH_W;

	logic                 have_first_q;
	logic signed [SW-1:0] held_q;
	logic                 accept;
	logic signed [SW:0]   x0_ext, x1_ext, sum_a, diff_d, neg_d, diff_kept;
	logic [SW:0]          mag_d;
	logic                 sup;

	assign in_stall = have_first_q && qstat.full;
	assign accept   = in_valid && !in_stall;

	assign x0_ext    = {held_q[SW-1], held_q};
	assign x1_ext    = {sample[SW-1], sample};
	assign sum_a     = x0_ext + x1_ext;
	assign diff_d    = x0_ext - x1_ext;
	assign neg_d     = -diff_d;
	assign mag_d     = diff_d[SW] ? neg_d : diff_d;
	assign sup       = CMP_W'(mag_d) < CMP_W'(threshold);
	assign diff_kept = sup ? '0 : diff_d;

	assign push      = accept && have_first_q;
	assign push_data = {sup, sum_a, diff_kept, held_q, sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			held_q       <= '0;
		end else if (accept) begin
			have_first_q <= !have_first_q;
			if (!have_first_q) begin
				held_q <= sample;
			end
		end
	end

endmodule

### hdl/hpt_back.sv
// Back part: rebuilds the pair, measures error, keeps saturating counters and sums.
// Depends on hpt_pkg; drains hpt_queue.
`timescale 1ns / 1ps

module hpt_back import hpt_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hpt_qstat_t                     qstat,
	input  logic [4*SAMPLE_WIDTH+2:0]      head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] recon_first,
	output logic signed [SAMPLE_WIDTH-1:0] recon_second,
	output logic                           was_suppressed,
	output logic [COUNT_W-1:0]             pair_count,
	output logic [COUNT_W-1:0]             suppressed_count,
	output logic [ABS_W-1:0]               abs_error_sum,
	output logic [SQ_W-1:0]                sq_error_sum
);

	localparam int SW      = SAMPLE_WIDTH;
	localparam int SQ_ADD  = 2 * SW + 1;
	localparam int SQ_SUMW = ((SQ_ADD > SQ_W) ? SQ_ADD : SQ_W) + 1;

	function automatic logic signed [SW-1:0] sat_fn(input logic signed [SW+1:0] v);
		logic [2:0] top;
		top = v[SW+1:SW-1];
		if (top != 3'b000 && top != 3'b111) begin
			return v[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return v[SW-1:0];
	endfunction

	logic adv;

	// stage 1: entry from queue
	logic                 v_s1, sup_s1;
	logic signed [SW:0]   a_s1, dp_s1;
	logic signed [SW-1:0] x0_s1, x1_s1;
	// stage 2: rebuilt samples
	logic                 v_s2, sup_s2;
	logic signed [SW-1:0] x0_s2, x1_s2, y0_s2, y1_s2;
	// stage 3: error magnitudes
	logic                 v_s3, sup_s3;
	logic signed [SW-1:0] y0_s3, y1_s3;
	logic [SW-1:0]        m0_s3, m1_s3;
	// stage 4: squares
	logic                 v_s4, sup_s4;
	logic signed [SW-1:0] y0_s4, y1_s4;
	logic [SW:0]          abs_s4;
	logic [2*SW-1:0]      sq0_s4, sq1_s4;
	// stage 5: square sum
	logic                 v_s5, sup_s5;
	logic signed [SW-1:0] y0_s5, y1_s5;
	logic [SW:0]          abs_s5;
	logic [SQ_ADD-1:0]    sq_s5;

	logic                 out_valid_q;
	logic signed [SW+1:0] t0, t1, r0, r1, h0, h1;
	logic signed [SW:0]   e0, e1, ne0, ne1;
	logic [SW-1:0]        m0, m1;
	logic [ABS_W:0]       abs_sum;
	logic [SQ_SUMW-1:0]   sq_sum;

	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !qstat.empty;
	assign out_valid = out_valid_q;

	assign t0 = {a_s1[SW], a_s1} + {dp_s1[SW], dp_s1};
	assign t1 = {a_s1[SW], a_s1} - {dp_s1[SW], dp_s1};
	// ties away from zero: negative halves floor, non-negative halves round up
	assign r0 = t0[SW+1] ? t0 : t0 + (SW+2)'(1);
	assign r1 = t1[SW+1] ? t1 : t1 + (SW+2)'(1);
	assign h0 = r0 >>> 1;
	assign h1 = r1 >>> 1;

	assign e0  = {x0_s2[SW-1], x0_s2} - {y0_s2[SW-1], y0_s2};
	assign e1  = {x1_s2[SW-1], x1_s2} - {y1_s2[SW-1], y1_s2};
	assign ne0 = -e0;
	assign ne1 = -e1;
	assign m0  = e0[SW] ? ne0[SW-1:0] : e0[SW-1:0];
	assign m1  = e1[SW] ? ne1[SW-1:0] : e1[SW-1:0];

	assign abs_sum = {1'b0, abs_error_sum} + (ABS_W+1)'(abs_s5);
	assign sq_sum  = SQ_SUMW'(sq_error_sum) + SQ_SUMW'(sq_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			{sup_s1, a_s1, dp_s1, x0_s1, x1_s1} <= head;
			sup_s2 <= sup_s1;
			x0_s2  <= x0_s1;
			x1_s2  <= x1_s1;
			y0_s2  <= sat_fn(h0);
			y1_s2  <= sat_fn(h1);
			sup_s3 <= sup_s2;
			y0_s3  <= y0_s2;
			y1_s3  <= y1_s2;
			m0_s3  <= m0;
			m1_s3  <= m1;
			sup_s4 <= sup_s3;
			y0_s4  <= y0_s3;
			y1_s4  <= y1_s3;
			abs_s4 <= {1'b0, m0_s3} + {1'b0, m1_s3};
			sq0_s4 <= (2*SW)'(m0_s3) * (2*SW)'(m0_s3);
			sq1_s4 <= (2*SW)'(m1_s3) * (2*SW)'(m1_s3);
			sup_s5 <= sup_s4;
			y0_s5  <= y0_s4;
			y1_s5  <= y1_s4;
			abs_s5 <= abs_s4;
			sq_s5  <= SQ_ADD'(sq0_s4) + SQ_ADD'(sq1_s4);
			if (v_s5) begin
				recon_first    <= y0_s5;
				recon_second   <= y1_s5;
				was_suppressed <= sup_s5;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			v_s3             <= 1'b0;
			v_s4             <= 1'b0;
			v_s5             <= 1'b0;
			out_valid_q      <= 1'b0;
			pair_count       <= '0;
			suppressed_count <= '0;
			abs_error_sum    <= '0;
			sq_error_sum     <= '0;
		end else if (adv) begin
			v_s1        <= !qstat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
			if (v_s5) begin
				if (pair_count != '1) begin
					pair_count <= pair_count + 1'b1;
				end
				if (sup_s5 && suppressed_count != '1) begin
					suppressed_count <= suppressed_count + 1'b1;
				end
				abs_error_sum <= abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
				sq_error_sum  <= (sq_sum[SQ_SUMW-1:SQ_W] != '0) ? '1 : sq_sum[SQ_W-1:0];
			end
		end
	end

endmodule

### hdl/haar_pair_threshold_denoiser.sv
// Top level of the Haar pair threshold denoiser: threshold register, front, queue, back.
// Depends on hpt_pkg, hpt_front, hpt_queue, hpt_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   input    | in_valid / in_stall   | sample
//   output   | out_valid / out_stall | recon_first, recon_second, was_suppressed,
//            |                       | pair_count, suppressed_count, abs/sq sums
//   config   | cfg_we                | cfg_wdata (threshold)
//
// One sample per cycle while in_stall is low; a result every second sample, via the
// queue and the back stages. Back pipeline (5 stages + output register)
// advances as one unit, gated by the output register. A 4-entry pair queue lets the
// front keep taking samples while the back is stalled; only a second sample meeting a
// full queue is stalled. Reset clears the pair phase, threshold, counters, sums.
`timescale 1ns / 1ps

module haar_pair_threshold_denoiser import hpt_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [THRESH_W-1:0]            cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] recon_first,
	output logic signed [SAMPLE_WIDTH-1:0] recon_second,
	output logic                           was_suppressed,
	output logic [COUNT_W-1:0]             pair_count,
	output logic [COUNT_W-1:0]             suppressed_count,
	output logic [ABS_W-1:0]               abs_error_sum,
	output logic [SQ_W-1:0]                sq_error_sum
);

	localparam int ENTRY_W = 4 * SAMPLE_WIDTH + 3;

	logic [THRESH_W-1:0] threshold_q;
	hpt_qstat_t          qstat;
	logic                push, pop;
	logic [ENTRY_W-1:0]  push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	hpt_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.threshold (threshold_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	hpt_queue #(.ENTRY_W(ENTRY_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	hpt_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.qstat            (qstat),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.recon_first      (recon_first),
		.recon_second     (recon_second),
		.was_suppressed   (was_suppressed),
		.pair_count       (pair_count),
		.suppressed_count (suppressed_count),
		.abs_error_sum    (abs_error_sum),
		.sq_error_sum     (sq_error_sum)
	);

endmodule

### hdl/hpt_checker.sv
// Port-level checker for the Haar pair threshold denoiser, bound to the top level.
// Depends on hpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpt_checker import hpt_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [SAMPLE_WIDTH-1:0] recon_first,
	input logic signed [SAMPLE_WIDTH-1:0] recon_second,
	input logic                           was_suppressed,
	input logic [COUNT_W-1:0]             pair_count,
	input logic [COUNT_W-1:0]             suppressed_count
);

	// a stalled transaction holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(recon_first) && $stable(pair_count))

	// a suppressed pair has a zeroed difference, so both rebuilt samples match
	`ASSERT_IMPL(a_sup_equal, clk, arst_n, out_valid && was_suppressed, recon_first == recon_second)

	`ASSERT_IMPL(a_sup_le_pairs, clk, arst_n, out_valid, suppressed_count <= pair_count)

	`ASSERT_IMPL(a_count_nonzero, clk, arst_n, out_valid, pair_count != '0)

endmodule

bind haar_pair_threshold_denoiser hpt_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_hpt_checker (.*);
